/* design/mdc_pkg.sv */
package mdc_pkg;

    localparam int MAX_EDGE    = 4;
    localparam int STORE_DEPTH = MAX_EDGE * MAX_EDGE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAX_EDGE);

    localparam int ELEM_W  = 16;
    localparam int SIZE_W  = 3;
    localparam int DET_W   = 64;
    localparam int MINOR_W = 34;   // 2x2 minor, |v| <= 2^31
    localparam int COF_W   = 52;   // 3x3 cofactor, |v| < 2^48
    localparam int ACC_W   = 70;   // 4x4 sum, |v| <= 2^66
    localparam int OPB_W   = 34;   // second multiplier operand
    localparam int PROD_W  = ELEM_W + OPB_W;
    localparam int HI_SHIFT = 26;  // cofactor split point for the multiplier

    localparam int N_MINOR = 6;
    localparam int N_COF   = 4;
    localparam int MIDX_W  = 3;
    localparam int CIDX_W  = 2;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_EDGE);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_MAX;

    localparam int SHIFT_2 = 16;
    localparam int SHIFT_3 = 8;

    localparam int PC_W     = 6;
    localparam int PROG_LEN = 46;
    localparam logic [PC_W-1:0] START_4 = 6'd0;
    localparam logic [PC_W-1:0] START_3 = 6'd34;
    localparam logic [PC_W-1:0] START_2 = 6'd44;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SUB   = 1'b1;
    localparam logic ACC_KEEP = 1'b0;
    localparam logic ACC_CLR  = 1'b1;
    localparam logic SEQ_MORE = 1'b0;
    localparam logic SEQ_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        SRC_ELEM   = 2'd0,
        SRC_MINOR  = 2'd1,
        SRC_COF_LO = 2'd2,
        SRC_COF_HI = 2'd3
    } t_src;

    typedef enum logic [1:0] {
        DST_NONE  = 2'd0,
        DST_MINOR = 2'd1,
        DST_COF   = 2'd2,
        DST_DET   = 2'd3
    } t_dst;

    // one multiply-accumulate step: acc[dst] (+|-)= elem[addr_a] * B
    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        t_src              src;
        logic [MIDX_W-1:0] src_idx;
        t_dst              dst;
        logic [MIDX_W-1:0] dst_idx;
        logic              neg;
        logic              clr;
        logic              last;
    } t_uop;

    function automatic logic [ADDR_W-1:0] ea(input int r, input int c);
        return ADDR_W'(r * MAX_EDGE + c);
    endfunction

    function automatic t_uop op_nop();
        t_uop u;
        u = '0;
        u.src = SRC_ELEM;
        u.dst = DST_NONE;
        return u;
    endfunction

    function automatic t_uop op_ee(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                   input t_dst dst, input logic [MIDX_W-1:0] di,
                                   input logic neg, input logic clr, input logic last);
        t_uop u;
        u = op_nop();
        u.addr_a = a;
        u.addr_b = b;
        u.src = SRC_ELEM;
        u.dst = dst;
        u.dst_idx = di;
        u.neg = neg;
        u.clr = clr;
        u.last = last;
        return u;
    endfunction

    function automatic t_uop op_em(input logic [ADDR_W-1:0] a, input logic [MIDX_W-1:0] mi,
                                   input t_dst dst, input logic [MIDX_W-1:0] di,
                                   input logic neg, input logic clr, input logic last);
        t_uop u;
        u = op_nop();
        u.addr_a = a;
        u.src = SRC_MINOR;
        u.src_idx = mi;
        u.dst = dst;
        u.dst_idx = di;
        u.neg = neg;
        u.clr = clr;
        u.last = last;
        return u;
    endfunction

    function automatic t_uop op_ec(input logic [ADDR_W-1:0] a, input t_src src,
                                   input logic [MIDX_W-1:0] ci,
                                   input logic neg, input logic clr, input logic last);
        t_uop u;
        u = op_nop();
        u.addr_a = a;
        u.src = src;
        u.src_idx = ci;
        u.dst = DST_DET;
        u.neg = neg;
        u.clr = clr;
        u.last = last;
        return u;
    endfunction

    // Microcode. 4x4: minors of rows 2-3 (pairs 01,02,03,12,13,23), then
    // row-1 cofactors, then row-0 expansion. 3x3: minors of rows 1-2, then
    // row-0 expansion. 2x2: ad - bc. A nop parts phases so a finished
    // accumulator is read only after its last write.
    function automatic t_uop prog_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = op_nop();
        case (pc)
            6'd0:  u = op_ee(ea(2,0), ea(3,1), DST_MINOR, 3'd0, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd1:  u = op_ee(ea(2,1), ea(3,0), DST_MINOR, 3'd0, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd2:  u = op_ee(ea(2,0), ea(3,2), DST_MINOR, 3'd1, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd3:  u = op_ee(ea(2,2), ea(3,0), DST_MINOR, 3'd1, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd4:  u = op_ee(ea(2,0), ea(3,3), DST_MINOR, 3'd2, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd5:  u = op_ee(ea(2,3), ea(3,0), DST_MINOR, 3'd2, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd6:  u = op_ee(ea(2,1), ea(3,2), DST_MINOR, 3'd3, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd7:  u = op_ee(ea(2,2), ea(3,1), DST_MINOR, 3'd3, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd8:  u = op_ee(ea(2,1), ea(3,3), DST_MINOR, 3'd4, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd9:  u = op_ee(ea(2,3), ea(3,1), DST_MINOR, 3'd4, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd10: u = op_ee(ea(2,2), ea(3,3), DST_MINOR, 3'd5, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd11: u = op_ee(ea(2,3), ea(3,2), DST_MINOR, 3'd5, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd12: u = op_nop();
            6'd13: u = op_em(ea(1,1), 3'd5, DST_COF, 3'd0, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd14: u = op_em(ea(1,2), 3'd4, DST_COF, 3'd0, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd15: u = op_em(ea(1,3), 3'd3, DST_COF, 3'd0, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd16: u = op_em(ea(1,0), 3'd5, DST_COF, 3'd1, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd17: u = op_em(ea(1,2), 3'd2, DST_COF, 3'd1, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd18: u = op_em(ea(1,3), 3'd1, DST_COF, 3'd1, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd19: u = op_em(ea(1,0), 3'd4, DST_COF, 3'd2, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd20: u = op_em(ea(1,1), 3'd2, DST_COF, 3'd2, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd21: u = op_em(ea(1,3), 3'd0, DST_COF, 3'd2, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd22: u = op_em(ea(1,0), 3'd3, DST_COF, 3'd3, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd23: u = op_em(ea(1,1), 3'd1, DST_COF, 3'd3, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd24: u = op_em(ea(1,2), 3'd0, DST_COF, 3'd3, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd25: u = op_nop();
            6'd26: u = op_ec(ea(0,0), SRC_COF_LO, 3'd0, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd27: u = op_ec(ea(0,0), SRC_COF_HI, 3'd0, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd28: u = op_ec(ea(0,1), SRC_COF_LO, 3'd1, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd29: u = op_ec(ea(0,1), SRC_COF_HI, 3'd1, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd30: u = op_ec(ea(0,2), SRC_COF_LO, 3'd2, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd31: u = op_ec(ea(0,2), SRC_COF_HI, 3'd2, OP_ADD, ACC_KEEP, SEQ_MORE);
            6'd32: u = op_ec(ea(0,3), SRC_COF_LO, 3'd3, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd33: u = op_ec(ea(0,3), SRC_COF_HI, 3'd3, OP_SUB, ACC_KEEP, SEQ_END);
            6'd34: u = op_ee(ea(1,0), ea(2,1), DST_MINOR, 3'd0, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd35: u = op_ee(ea(1,1), ea(2,0), DST_MINOR, 3'd0, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd36: u = op_ee(ea(1,0), ea(2,2), DST_MINOR, 3'd1, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd37: u = op_ee(ea(1,2), ea(2,0), DST_MINOR, 3'd1, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd38: u = op_ee(ea(1,1), ea(2,2), DST_MINOR, 3'd2, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd39: u = op_ee(ea(1,2), ea(2,1), DST_MINOR, 3'd2, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd40: u = op_nop();
            6'd41: u = op_em(ea(0,0), 3'd2, DST_DET, 3'd0, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd42: u = op_em(ea(0,1), 3'd1, DST_DET, 3'd0, OP_SUB, ACC_KEEP, SEQ_MORE);
            6'd43: u = op_em(ea(0,2), 3'd0, DST_DET, 3'd0, OP_ADD, ACC_KEEP, SEQ_END);
            6'd44: u = op_ee(ea(0,0), ea(1,1), DST_DET, 3'd0, OP_ADD, ACC_CLR,  SEQ_MORE);
            6'd45: u = op_ee(ea(0,1), ea(1,0), DST_DET, 3'd0, OP_SUB, ACC_KEEP, SEQ_END);
            default: u = op_nop();
        endcase
        return u;
    endfunction

endpackage

/* design/mdc_elem_if.sv */
interface mdc_elem_if;
    logic                               valid;
    logic                               ready;
    logic signed [mdc_pkg::ELEM_W-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

/* design/mdc_det_if.sv */
interface mdc_det_if;
    logic                               valid;
    logic                               ready;
    logic signed [mdc_pkg::DET_W-1:0]   det_value;
    logic                               overflowed;

    modport source (output valid, output det_value, output overflowed, input ready);
    modport sink   (input valid, input det_value, input overflowed, output ready);
endinterface

/* design/mdc_ram.sv */
module mdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* design/matrix_determinant_cofactor_core.sv */
// After the last element beat the microcode runs: 2, 10 or 34 steps (2x2, 3x3, 4x4), each one
//   passing store read, multiply and accumulate; the result register then loads det_value.
// One shared 16x34 multiplier serves every step.
// Input ready only while loading; the result register frees the load of the next matrix.
// Reset (i_rst_n low, synchronous): size back to 4x4, load count and pipeline cleared;
//   element store contents are left as they are and are always rewritten before use.
module matrix_determinant_cofactor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mdc_pkg::SIZE_W-1:0]    i_cfg_data,
    mdc_elem_if.sink                      i_elem,
    mdc_det_if.source                     o_det
);
    import mdc_pkg::*;

    // ---------------------------------------------------------------------
    // Control: load counters, sequencer
    // ---------------------------------------------------------------------
    t_state                 r_state;
    logic [IDX_W-1:0]       r_row;
    logic [IDX_W-1:0]       r_col;
    logic [SIZE_W-1:0]      r_size;
    logic [SIZE_W-1:0]      n_size;
    logic [PC_W-1:0]        r_pc;
    logic [PC_W-1:0]        start_pc;
    t_uop                   cur_op;

    logic                   elem_acc;
    logic                   col_end;
    logic                   row_end;
    logic                   out_load;

    // Pipeline: S0 issues store reads, S1 multiplies, S2 accumulates.
    logic                   r_v1;
    logic                   r_v2;
    t_uop                   r_op1;
    t_uop                   r_op2;
    logic [ELEM_W-1:0]      q_a;
    logic [ELEM_W-1:0]      q_b;
    logic signed [OPB_W-1:0]  opnd_b;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;

    // Accumulators: minors, cofactors, final determinant.
    logic signed [MINOR_W-1:0] r_minor [N_MINOR];
    logic signed [COF_W-1:0]   r_cof [N_COF];
    logic signed [ACC_W-1:0]   r_det;
    logic signed [ACC_W-1:0]   acc_term;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [COF_W-1:0]   cof_sel;
    logic                      r_done;

    // Result register.
    logic                      r_out_valid;
    logic signed [DET_W-1:0]   r_out_det;
    logic                      r_out_ovf;
    logic signed [DET_W-1:0]   n_out_det;
    logic                      n_out_ovf;
    logic                      det_fits;

    assign elem_acc = i_elem.valid && i_elem.ready;
    assign col_end  = (SIZE_W'(r_col) == r_size - 3'd1);
    assign row_end  = (SIZE_W'(r_row) == r_size - 3'd1);
    assign cur_op   = prog_rom(r_pc);
    assign out_load = (r_state == ST_FLUSH) && r_done && (!r_out_valid || o_det.ready);

    assign i_elem.ready    = (r_state == ST_LOAD);
    assign o_det.valid     = r_out_valid;
    assign o_det.det_value = r_out_det;
    assign o_det.overflowed = r_out_ovf;

    // Size register clamps to the supported range.
    always_comb begin
        if (i_cfg_data < SIZE_MIN) begin
            n_size = SIZE_MIN;
        end else if (i_cfg_data > SIZE_MAX) begin
            n_size = SIZE_MAX;
        end else begin
            n_size = i_cfg_data;
        end
    end

    always_comb begin
        case (r_size)
            3'd2:    start_pc = START_2;
            3'd3:    start_pc = START_3;
            default: start_pc = START_4;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_row       <= '0;
            r_col       <= '0;
            r_size      <= SIZE_RESET;
            r_pc        <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_RUN);
            r_v2 <= r_v1;

            if (r_v2 && r_op2.last) begin
                r_done <= 1'b1;
            end else if (out_load) begin
                r_done <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_det.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (i_cfg_we) begin
                        // new size drops any partly loaded matrix
                        r_size <= n_size;
                        r_row  <= '0;
                        r_col  <= '0;
                    end else if (elem_acc) begin
                        if (col_end) begin
                            r_col <= '0;
                            if (row_end) begin
                                r_row   <= '0;
                                r_pc    <= start_pc;
                                r_state <= ST_RUN;
                            end else begin
                                r_row <= r_row + IDX_W'(1);
                            end
                        end else begin
                            r_col <= r_col + IDX_W'(1);
                        end
                    end
                end
                ST_RUN: begin
                    if (cur_op.last) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_pc <= r_pc + PC_W'(1);
                    end
                end
                ST_FLUSH: begin
                    if (out_load) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Element store: row-major at row*MAX_EDGE+col, whatever the size
    // ---------------------------------------------------------------------
    mdc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (elem_acc),
        .i_waddr   ({r_row, r_col}),
        .i_wdata   (i_elem.element_value),
        .i_raddr_a (cur_op.addr_a),
        .i_raddr_b (cur_op.addr_b),
        .o_rdata_a (q_a),
        .o_rdata_b (q_b)
    );

    // ---------------------------------------------------------------------
    // S1: operand select and the shared multiplier
    // ---------------------------------------------------------------------
    assign cof_sel = r_cof[r_op1.src_idx[CIDX_W-1:0]];

    always_comb begin
        case (r_op1.src)
            SRC_ELEM:   opnd_b = OPB_W'($signed(q_b));
            SRC_MINOR:  opnd_b = r_minor[r_op1.src_idx];
            // cofactor = hi * 2^26 + lo, lo taken unsigned
            SRC_COF_LO: opnd_b = $signed({{(OPB_W-HI_SHIFT){1'b0}}, cof_sel[HI_SHIFT-1:0]});
            SRC_COF_HI: opnd_b = OPB_W'($signed(cof_sel[COF_W-1:HI_SHIFT]));
            default:    opnd_b = '0;
        endcase
    end

    assign n_prod = $signed(q_a) * opnd_b;

    // ---------------------------------------------------------------------
    // S2: accumulate into the addressed register
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_op2.src == SRC_COF_HI) begin
            acc_term = ACC_W'(r_prod) <<< HI_SHIFT;
        end else begin
            acc_term = ACC_W'(r_prod);
        end

        case (r_op2.dst)
            DST_MINOR: acc_base = ACC_W'(r_minor[r_op2.dst_idx]);
            DST_COF:   acc_base = ACC_W'(r_cof[r_op2.dst_idx[CIDX_W-1:0]]);
            DST_DET:   acc_base = r_det;
            default:   acc_base = '0;
        endcase
        if (r_op2.clr) begin
            acc_base = '0;
        end

        n_acc = r_op2.neg ? (acc_base - acc_term) : (acc_base + acc_term);
    end

    // ---------------------------------------------------------------------
    // Output scaling to Q32.32; only a 4x4 result can leave 64 bits
    // ---------------------------------------------------------------------
    assign det_fits = (&r_det[ACC_W-1:DET_W-1]) || !(|r_det[ACC_W-1:DET_W-1]);

    always_comb begin
        n_out_ovf = 1'b0;
        case (r_size)
            3'd2: n_out_det = {r_det[DET_W-1-SHIFT_2:0], {SHIFT_2{1'b0}}};
            3'd3: n_out_det = {r_det[DET_W-1-SHIFT_3:0], {SHIFT_3{1'b0}}};
            default: begin
                if (det_fits) begin
                    n_out_det = r_det[DET_W-1:0];
                end else begin
                    n_out_ovf = 1'b1;
                    n_out_det = r_det[ACC_W-1] ? {1'b1, {(DET_W-1){1'b0}}}
                                               : {1'b0, {(DET_W-1){1'b1}}};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op1  <= cur_op;
        r_op2  <= r_op1;
        r_prod <= n_prod;
        if (r_v2) begin
            case (r_op2.dst)
                DST_MINOR: r_minor[r_op2.dst_idx] <= n_acc[MINOR_W-1:0];
                DST_COF:   r_cof[r_op2.dst_idx[CIDX_W-1:0]] <= n_acc[COF_W-1:0];
                DST_DET:   r_det <= n_acc;
                default: ;
            endcase
        end
        if (out_load) begin
            r_out_det <= n_out_det;
            r_out_ovf <= n_out_ovf;
        end
    end

`ifndef NO_ASSERTIONS
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size >= SIZE_MIN) && (r_size <= SIZE_MAX))
        else $error("matrix size register out of range");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (elem_acc && !i_cfg_we && col_end && row_end) |=> !i_elem.ready)
        else $error("still ready after the last element beat");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_done))
        else $error("result shown before the sequence finished");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pc < PC_W'(PROG_LEN)))
        else $error("sequencer ran past the microcode");

    a_drained_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !r_v2)
        else $error("accumulate step in flight while loading");
`endif

endmodule
